### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the occupation search block.
// Each macro expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define AOS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/aos_pkg.sv
// Shared constants and types for the occupation search block.
// No dependencies; used by the store and the top level.
package aos_pkg;

  localparam int MAX_ORBITALS_DEF = 256;
  localparam int GROUPS_DEF       = 8;

  // Configuration port geometry
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 31;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ALPHA  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BETA   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_ECOUNT = 3'd3;
  localparam logic [CFG_IW-1:0] REG_TOL    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_CLOSED = 3'd5;

  // Energy tolerance after reset, about 0.001 Hartree in Q12.20
  localparam logic [30:0] TOL_RESET = 31'd1049;

  // Error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_OCC   = 2'd1;
  localparam logic [1:0] ERR_START = 2'd2;

  // One stored orbital
  typedef struct packed {
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic [2:0]         grp;
  } store_word_t;

endpackage

### hdl/aos_if.sv
// Valid/ready channel interfaces for orbital input and group result rows.
// Depends on nothing beyond the language.
interface aos_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] alpha_energy;
  logic signed [31:0] beta_energy;
  logic [2:0]         group;
  logic               last;

  modport source (output valid, alpha_energy, beta_energy, group, last, input ready);
  modport sink   (input valid, alpha_energy, beta_energy, group, last, output ready);
endinterface

interface aos_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         group_index;
  logic [8:0]         alpha_in_group;
  logic [8:0]         beta_in_group;
  logic [8:0]         alpha_total;
  logic [8:0]         beta_total;
  logic signed [47:0] total_energy;
  logic [1:0]         error_code;
  logic               final_row;

  modport source (output valid, group_index, alpha_in_group, beta_in_group, alpha_total,
                  beta_total, total_energy, error_code, final_row, input ready);
  modport sink   (input valid, group_index, alpha_in_group, beta_in_group, alpha_total,
                  beta_total, total_energy, error_code, final_row, output ready);
endinterface

### hdl/aufbau_occupation_search_core.sv
// Aufbau occupation search. Orbitals load at one transaction per cycle while the block is
// idle; the transaction marked last starts the ranking, and input stays stalled until the
// final group row has been registered for output. After n orbitals the block ranks both
// spins with one shared key comparator pair walking the store, then runs each Hund search
// step (mode 1) through S_SR_CHK, S_SR_ORD and S_SR_CMP, sums the energies and counts the
// groups of the occupied alpha and beta orbitals through S_FL_CHK, S_FL_ORD and S_FL_ACC,
// and emits the GROUPS result rows; the store has a single read port per memory.
`include "assert_macros.svh"

module aufbau_occupation_search_core #(
  parameter int MAX_ORBITALS = aos_pkg::MAX_ORBITALS_DEF,
  parameter int GROUPS       = aos_pkg::GROUPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [aos_pkg::CFG_IW-1:0] cfg_index,
  input  logic [aos_pkg::CFG_DW-1:0] cfg_data,
  aos_in_if.sink                     in_ch,
  aos_out_if.source                  out_ch
);

  localparam int IW  = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;
  localparam int CW  = $clog2(MAX_ORBITALS + 1);
  localparam int NW  = (CW > 11) ? CW : 11;
  localparam int GIW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam logic [2:0] GI_LAST = 3'(GROUPS - 1);

  typedef enum logic [12:0] {
    S_IDLE    = 13'h0001,
    S_RK_KEY  = 13'h0002,
    S_RK_LAT  = 13'h0004,
    S_RK_SCAN = 13'h0008,
    S_RK_WR   = 13'h0010,
    S_DEC     = 13'h0020,
    S_SR_CHK  = 13'h0040,
    S_SR_ORD  = 13'h0080,
    S_SR_CMP  = 13'h0100,
    S_FL_CHK  = 13'h0200,
    S_FL_ORD  = 13'h0400,
    S_FL_ACC  = 13'h0800,
    S_EMIT    = 13'h1000
  } state_t;

  state_t state;

  // Configuration registers
  logic        cfg_mode;
  logic [8:0]  cfg_alpha;
  logic [8:0]  cfg_beta;
  logic [9:0]  cfg_ecount;
  logic [30:0] cfg_tol;
  logic        cfg_closed;

  // Load and ranking
  logic [CW-1:0]      count;
  logic [CW-1:0]      n;
  logic [NW-1:0]      n_ext;
  logic [IW-1:0]      i;
  logic [IW-1:0]      jr;
  logic [IW-1:0]      rank_a;
  logic [IW-1:0]      rank_b;
  logic signed [31:0] key_a;
  logic signed [31:0] key_b;
  logic [2:0]         key_g;
  logic               lt_a;
  logic               lt_b;
  logic               j_first;

  // Search and fill
  logic [NW-1:0]      a;
  logic [NW-1:0]      b;
  logic [NW-1:0]      k;
  logic               fb;
  logic [1:0]         err;
  logic [8:0]         cnt_a [GROUPS];
  logic [8:0]         cnt_b [GROUPS];
  logic signed [47:0] sum;
  logic signed [32:0] step;
  logic               take;
  logic signed [31:0] fill_e;
  logic [GIW-1:0]     fill_g;

  // Decision of start counts
  logic [NW-1:0]      dec_a;
  logic [NW-1:0]      dec_b;
  logic [1:0]         dec_err;
  logic [NW-1:0]      ha;
  logic [NW-1:0]      hb;

  // Rank order memories
  logic [IW-1:0] ord_a_mem [MAX_ORBITALS];
  logic [IW-1:0] ord_b_mem [MAX_ORBITALS];
  logic [IW-1:0] ord_a_rd;
  logic [IW-1:0] ord_b_rd;
  logic [IW-1:0] ord_a_addr;
  logic [IW-1:0] ord_b_addr;

  // Store ports
  logic                 in_acc;
  logic                 st_we;
  aos_pkg::store_word_t st_wdata;
  aos_pkg::store_word_t st_rd;
  logic [IW-1:0]        rk_addr;
  logic [IW-1:0]        ra_addr;
  logic [IW-1:0]        rb_addr;
  logic [IW-1:0]        rg_addr;

  // Output register
  logic               ov;
  logic [2:0]         r;
  logic [2:0]         o_gi;
  logic [8:0]         o_ag;
  logic [8:0]         o_bg;
  logic [8:0]         o_at;
  logic [8:0]         o_bt;
  logic signed [47:0] o_sum;
  logic [1:0]         o_err;
  logic               o_final;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign n_ext       = NW'(n);

  // Clamp the group and write while there is room
  assign st_we          = in_acc && (count < CW'(MAX_ORBITALS));
  assign st_wdata.alpha = in_ch.alpha_energy;
  assign st_wdata.beta  = in_ch.beta_energy;
  assign st_wdata.grp   = ({1'b0, in_ch.group} >= 4'(GROUPS)) ? GI_LAST : in_ch.group;

  // Pick store read addresses
  always_comb begin
    unique case (state)
      S_RK_KEY:  rk_addr = i;
      S_RK_SCAN: rk_addr = jr + IW'(1);
      default:   rk_addr = '0;
    endcase
    if (state == S_RK_KEY || state == S_RK_LAT || state == S_RK_SCAN) begin
      ra_addr = rk_addr;
      rb_addr = rk_addr;
      rg_addr = rk_addr;
    end else begin
      ra_addr = ord_a_rd;
      rb_addr = ord_b_rd;
      rg_addr = fb ? ord_b_rd : ord_a_rd;
    end
  end

  aos_store #(
    .DEPTH (MAX_ORBITALS),
    .IW    (IW)
  ) u_store (
    .clk        (clk),
    .we         (st_we),
    .waddr      (count[IW-1:0]),
    .wdata      (st_wdata),
    .alpha_addr (ra_addr),
    .beta_addr  (rb_addr),
    .grp_addr   (rg_addr),
    .rdata      (st_rd)
  );

  // Order key (energy, group, load position) of the scanned orbital against the held one
  assign j_first = jr < i;
  assign lt_a = (st_rd.alpha < key_a) ||
                (st_rd.alpha == key_a && (st_rd.grp < key_g ||
                                          (st_rd.grp == key_g && j_first)));
  assign lt_b = (st_rd.beta < key_b) ||
                (st_rd.beta == key_b && (st_rd.grp < key_g ||
                                         (st_rd.grp == key_g && j_first)));

  // Order memory addresses
  always_comb begin
    if (state == S_SR_CHK) begin
      ord_a_addr = a[IW-1:0];
      ord_b_addr = IW'(b - NW'(1));
    end else begin
      ord_a_addr = k[IW-1:0];
      ord_b_addr = k[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RK_WR) begin
      ord_a_mem[rank_a] <= i;
      ord_b_mem[rank_b] <= i;
    end
    ord_a_rd <= ord_a_mem[ord_a_addr];
    ord_b_rd <= ord_b_mem[ord_b_addr];
  end

  // Start counts and start checks
  always_comb begin
    ha      = NW'(({1'b0, cfg_ecount} + 11'd1) >> 1);
    hb      = NW'(cfg_ecount >> 1);
    dec_err = aos_pkg::ERR_OK;
    if (!cfg_mode) begin
      dec_a = NW'(cfg_alpha);
      dec_b = NW'(cfg_beta);
      if (dec_a > n_ext || dec_b > n_ext) dec_err = aos_pkg::ERR_OCC;
    end else begin
      dec_a = ha;
      dec_b = hb;
      if (!cfg_closed && ha == hb) begin
        if (hb == '0) begin
          dec_err = aos_pkg::ERR_START;
        end else begin
          dec_a = ha + NW'(1);
          dec_b = hb - NW'(1);
        end
      end
      if (dec_err == aos_pkg::ERR_OK && dec_a > n_ext) dec_err = aos_pkg::ERR_OCC;
    end
  end

  // Hund step: alpha gained minus beta lost, against the tolerance
  assign step = {st_rd.alpha[31], st_rd.alpha} - {st_rd.beta[31], st_rd.beta};
  assign take = step < $signed({2'b00, cfg_tol});

  assign fill_e = fb ? st_rd.beta : st_rd.alpha;
  assign fill_g = st_rd.grp[GIW-1:0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode   <= 1'b0;
      cfg_alpha  <= '0;
      cfg_beta   <= '0;
      cfg_ecount <= '0;
      cfg_tol    <= aos_pkg::TOL_RESET;
      cfg_closed <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aos_pkg::REG_MODE:   cfg_mode   <= cfg_data[0];
        aos_pkg::REG_ALPHA:  cfg_alpha  <= cfg_data[8:0];
        aos_pkg::REG_BETA:   cfg_beta   <= cfg_data[8:0];
        aos_pkg::REG_ECOUNT: cfg_ecount <= cfg_data[9:0];
        aos_pkg::REG_TOL:    cfg_tol    <= cfg_data[30:0];
        aos_pkg::REG_CLOSED: cfg_closed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ov    <= 1'b0;
    end else begin
      // Drop a taken row; while emitting, the emit arm reloads it
      if (ov && out_ch.ready && state != S_EMIT) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (st_we) count <= count + CW'(1);
            if (in_ch.last) begin
              n     <= st_we ? count + CW'(1) : count;
              count <= '0;
              i     <= '0;
              state <= S_RK_KEY;
            end
          end
        end
        S_RK_KEY: state <= S_RK_LAT;
        S_RK_LAT: begin
          key_a  <= st_rd.alpha;
          key_b  <= st_rd.beta;
          key_g  <= st_rd.grp;
          rank_a <= '0;
          rank_b <= '0;
          jr     <= '0;
          state  <= S_RK_SCAN;
        end
        S_RK_SCAN: begin
          rank_a <= rank_a + IW'(lt_a);
          rank_b <= rank_b + IW'(lt_b);
          if (CW'(jr) + CW'(1) == n) state <= S_RK_WR;
          else jr <= jr + IW'(1);
        end
        S_RK_WR: begin
          if (CW'(i) + CW'(1) == n) begin
            state <= S_DEC;
          end else begin
            i     <= i + IW'(1);
            state <= S_RK_KEY;
          end
        end
        S_DEC: begin
          for (int g = 0; g < GROUPS; g++) begin
            cnt_a[g] <= '0;
            cnt_b[g] <= '0;
          end
          sum <= '0;
          k   <= '0;
          fb  <= 1'b0;
          r   <= '0;
          err <= dec_err;
          if (dec_err != aos_pkg::ERR_OK) begin
            a     <= '0;
            b     <= '0;
            state <= S_EMIT;
          end else begin
            a     <= dec_a;
            b     <= dec_b;
            state <= cfg_mode ? S_SR_CHK : S_FL_CHK;
          end
        end
        S_SR_CHK: state <= (b != '0 && a < n_ext) ? S_SR_ORD : S_FL_CHK;
        S_SR_ORD: state <= S_SR_CMP;
        S_SR_CMP: begin
          if (take) begin
            a     <= a + NW'(1);
            b     <= b - NW'(1);
            state <= S_SR_CHK;
          end else begin
            state <= S_FL_CHK;
          end
        end
        S_FL_CHK: begin
          if (k < (fb ? b : a)) begin
            state <= S_FL_ORD;
          end else if (!fb) begin
            fb <= 1'b1;
            k  <= '0;
          end else begin
            state <= S_EMIT;
          end
        end
        S_FL_ORD: state <= S_FL_ACC;
        S_FL_ACC: begin
          sum <= sum + {{16{fill_e[31]}}, fill_e};
          if (fb) cnt_b[fill_g] <= cnt_b[fill_g] + 9'd1;
          else    cnt_a[fill_g] <= cnt_a[fill_g] + 9'd1;
          k     <= k + NW'(1);
          state <= S_FL_CHK;
        end
        S_EMIT: begin
          if (!ov || out_ch.ready) begin
            ov      <= 1'b1;
            o_gi    <= r;
            o_ag    <= cnt_a[r[GIW-1:0]];
            o_bg    <= cnt_b[r[GIW-1:0]];
            o_at    <= a[8:0];
            o_bt    <= b[8:0];
            o_sum   <= sum;
            o_err   <= err;
            o_final <= (r == GI_LAST);
            r       <= r + 3'd1;
            if (r == GI_LAST) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Drive the result channel
  assign out_ch.valid          = ov;
  assign out_ch.group_index    = o_gi;
  assign out_ch.alpha_in_group = o_ag;
  assign out_ch.beta_in_group  = o_bg;
  assign out_ch.alpha_total    = o_at;
  assign out_ch.beta_total     = o_bt;
  assign out_ch.total_energy   = o_sum;
  assign out_ch.error_code     = o_err;
  assign out_ch.final_row      = o_final;

  `AOS_ASSERT_IMP(a_fill_in_range, state == S_FL_CHK, a <= n_ext && b <= n_ext, "fill count beyond loaded orbitals")
  `AOS_ASSERT_NXT(a_step_keeps_total, state == S_SR_CMP && take, a + b == $past(a + b), "search step changed electron total")
  `AOS_ASSERT_IMP(a_err_rows_zero, ov && o_err != aos_pkg::ERR_OK, o_at == 9'd0 && o_bt == 9'd0 && o_sum == 48'sd0, "error row carries occupation")
  `AOS_ASSERT_IMP(a_final_row_group, ov && o_final, o_gi == GI_LAST, "final row not on last group")

endmodule

### hdl/aos_store.sv
// Orbital store: alpha energy, beta energy and group memories.
// One write port, three registered read ports. Uses aos_pkg::store_word_t.
module aos_store #(
  parameter int DEPTH = aos_pkg::MAX_ORBITALS_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IW-1:0]       waddr,
  input  aos_pkg::store_word_t wdata,
  input  logic [IW-1:0]       alpha_addr,
  input  logic [IW-1:0]       beta_addr,
  input  logic [IW-1:0]       grp_addr,
  output aos_pkg::store_word_t rdata
);

  logic signed [31:0] alpha_mem [DEPTH];
  logic signed [31:0] beta_mem  [DEPTH];
  logic [2:0]         grp_mem   [DEPTH];

  // Write one orbital
  always_ff @(posedge clk) begin
    if (we) begin
      alpha_mem[waddr] <= wdata.alpha;
      beta_mem[waddr]  <= wdata.beta;
      grp_mem[waddr]   <= wdata.grp;
    end
  end

  // Registered reads, each at its own address
  always_ff @(posedge clk) begin
    rdata.alpha <= alpha_mem[alpha_addr];
    rdata.beta  <= beta_mem[beta_addr];
    rdata.grp   <= grp_mem[grp_addr];
  end

endmodule
